### sv/tgadec_pkg.sv
// tgadec_pkg: shared types and codes for the TGA true-color RLE decoder.
// Beat structs, status/phase/kind codes, header byte offsets, divider interface.
// No dependencies.
package tgadec_pkg;

    // one byte of the file per input beat
    typedef struct packed {
        logic [7:0] data_byte;
        logic       final_byte;
    } t_in_beat;

    // one result per output beat
    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] dest_x;
        logic [15:0] dest_y;
        logic [7:0]  run_length;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [15:0] image_width;
        logic [15:0] image_height;
        logic        image_done;
    } t_out_beat;

    // result status codes
    localparam logic [2:0] ST_HEADER      = 3'd0;
    localparam logic [2:0] ST_RUN         = 3'd1;
    localparam logic [2:0] ST_UNSUPPORTED = 3'd2;
    localparam logic [2:0] ST_BAD_DEPTH   = 3'd3;
    localparam logic [2:0] ST_TRUNCATED   = 3'd4;

    // parser phases
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_IDLE   = 3'd4;

    // image kind
    localparam logic [3:0] KIND_NONE        = 4'd0;
    localparam logic [3:0] KIND_RAW         = 4'd2;
    localparam logic [3:0] KIND_RLE         = 4'd10;
    localparam logic [3:0] KIND_BAD_DEPTH   = 4'd14;
    localparam logic [3:0] KIND_UNSUPPORTED = 4'd15;

    // header field values
    localparam logic [7:0] IMG_TYPE_RAW = 8'd2;
    localparam logic [7:0] IMG_TYPE_RLE = 8'd10;
    localparam logic [7:0] DEPTH_24     = 8'd24;
    localparam logic [7:0] DEPTH_32     = 8'd32;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam int         DESC_TOP_DOWN_BIT = 5;
    localparam int         PKT_REPEAT_BIT    = 7;

    // header byte offsets
    localparam logic [4:0] HDR_ID_LEN    = 5'd0;
    localparam logic [4:0] HDR_CMAP_TYPE = 5'd1;
    localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
    localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
    localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
    localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
    localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
    localparam logic [4:0] HDR_DEPTH     = 5'd16;
    localparam logic [4:0] HDR_DESC      = 5'd17;

    // row/column divider: quotient never exceeds 128 (run <= 128, column < width)
    localparam int DIV_QUOT_W = 8;
    localparam int DIV_STEP_W = 3;
    localparam int DIV_REM_W  = 17;

    typedef struct packed {
        logic                 start;
        logic [DIV_REM_W-1:0] dividend;
        logic [15:0]          divisor;
    } t_div_req;

    typedef struct packed {
        logic                  busy;
        logic                  done;
        logic [DIV_QUOT_W-1:0] quot;
        logic [15:0]           rem;
    } t_div_rsp;

endpackage

### sv/tga_truecolor_rle_decoder.sv
// tga_truecolor_rle_decoder: top level of the TGA 24/32 bpp decoder.
// Holds the result register and beat flow control around tgadec_core/tgadec_div.
// Depends on tgadec_pkg, tgadec_div, tgadec_core.
//
//  channel | direction | handshake                 | beat
//  --------+-----------+---------------------------+--------------------------------
//  in      | sink      | i_in_valid / o_in_stall   | t_in_beat: one file byte + last
//  out     | source    | o_out_valid / i_out_stall | t_out_beat: header, run or error
//
// One byte per cycle while the input is not stalled. Each byte is decoded in the cycle
// it is taken and its result, if any, sits in the result register on the next cycle.
// A repeat run that lands two or more rows past its start column (col + length
// >= 2 * width) holds the input while the restoring divider splits it into row
// advance and column; the byte after such a run is a packet header.
// Reset is synchronous and active low; no clearing pass.
// The result register is one deep: while it is full and the output is stalled the
// input is stalled too.
module tga_truecolor_rle_decoder
    import tgadec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_beat  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_beat o_out_data
);

    logic      r_out_valid;
    t_out_beat r_out_data;

    logic      accept;
    logic      out_free;
    logic      res_valid;
    t_out_beat res;
    t_div_req  div_req;
    t_div_rsp  div_rsp;

    // result register can take a new beat when empty or being drained
    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = div_rsp.busy || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    tgadec_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_beat      (i_in_data),
        .i_div_rsp   (div_rsp),
        .o_div_req   (div_req),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    tgadec_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= res_valid;
        end
    end

    // payload only moves when a new result is loaded
    always_ff @(posedge i_clk) begin
        if (out_free && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

### sv/tgadec_div.sv
// tgadec_div: restoring divider, one quotient bit per cycle.
// Splits column + run length into row advance and new column.
// Depends on tgadec_pkg.
module tgadec_div
    import tgadec_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic                  r_busy;
    logic                  r_done;
    logic [DIV_STEP_W-1:0] r_step;
    logic [DIV_REM_W-1:0]  r_rem;
    logic [DIV_QUOT_W-1:0] r_quot;
    logic [15:0]           r_divisor;

    logic [23:0] trial_div;
    logic [23:0] rem_ext;
    logic        take;

    always_comb begin
        trial_div = {8'd0, r_divisor} << r_step;
        rem_ext   = {7'd0, r_rem};
        take      = rem_ext >= trial_div;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_step <= DIV_STEP_W'(DIV_QUOT_W - 1);
            end else if (r_busy) begin
                r_step <= r_step - DIV_STEP_W'(1);
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem     <= i_req.dividend;
            r_quot    <= '0;
            r_divisor <= i_req.divisor;
        end else if (r_busy && take) begin
            r_rem          <= DIV_REM_W'(rem_ext - trial_div);
            r_quot[r_step] <= 1'b1;
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem[15:0];

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider started while busy");
    a_last_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && r_step == '0 && !i_req.start) |=> (!r_busy && r_done))
        else $error("divider did not finish after last step");
    a_rem_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_rem < {1'b0, r_divisor}))
        else $error("divider remainder out of range");
`endif

endmodule

### sv/tgadec_core.sv
// tgadec_core: byte parser. Header fields, ID skip, packet headers, pixel assembly.
// One accepted byte updates state and forms at most one result in the same cycle.
// Depends on tgadec_pkg; row/column wrap of long runs is handed to tgadec_div.
module tgadec_core
    import tgadec_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_beat  i_beat,
    input  t_div_rsp  i_div_rsp,
    output t_div_req  o_div_req,
    output logic      o_res_valid,
    output t_out_beat o_res
);

    logic [4:0]  r_hdr_idx,  n_hdr_idx;
    logic [7:0]  r_id_skip,  n_id_skip;
    logic [3:0]  r_kind,     n_kind;
    logic [15:0] r_width,    n_width;
    logic [15:0] r_height,   n_height;
    logic        r_four,     n_four;
    logic        r_top_down, n_top_down;
    logic [15:0] r_col,      n_col;
    logic [15:0] r_row,      n_row;
    logic [7:0]  r_pkt_left, n_pkt_left;
    logic        r_repeat,   n_repeat;
    logic [1:0]  r_bip,      n_bip;
    logic [31:0] r_colour,   n_colour;
    logic [2:0]  r_phase,    n_phase;
    logic [31:0] r_left,     n_left;   // pixels still owed to the image

    logic [7:0]  b;
    logic [31:0] byte_shifted;
    logic        pix_done;
    logic [7:0]  want;
    logic [7:0]  len;
    logic [16:0] pos;
    logic [16:0] pos_m_w;
    logic [2:0]  data_phase;
    logic        hdr_valid;
    logic [2:0]  hdr_status;
    logic        run_valid;
    t_out_beat   res;
    t_div_req    div_req;

    always_comb begin
        b = i_beat.data_byte;

        n_hdr_idx  = r_hdr_idx;
        n_id_skip  = r_id_skip;
        n_kind     = r_kind;
        n_width    = r_width;
        n_height   = r_height;
        n_four     = r_four;
        n_top_down = r_top_down;
        n_col      = r_col;
        n_row      = r_row;
        n_pkt_left = r_pkt_left;
        n_repeat   = r_repeat;
        n_bip      = r_bip;
        n_colour   = r_colour;
        n_phase    = r_phase;
        n_left     = r_left;

        hdr_valid  = 1'b0;
        hdr_status = ST_HEADER;
        run_valid  = 1'b0;
        res        = '0;

        div_req          = '0;
        pos              = {1'b0, r_col};
        pos_m_w          = '0;
        byte_shifted     = {24'd0, b} << {r_bip, 3'b000};
        pix_done         = 1'b0;
        want             = 8'd1;
        len              = 8'd1;

        // where data starts once header and ID are done
        if (r_width == 16'd0 || r_height == 16'd0) begin
            data_phase = PH_IDLE;
        end else if (r_kind == KIND_RLE) begin
            data_phase = PH_PACKET;
        end else begin
            data_phase = PH_PIXEL;
        end

        // row/column split of a long run lands here
        if (i_div_rsp.done) begin
            n_row = r_row + {8'd0, i_div_rsp.quot};
            n_col = i_div_rsp.rem;
        end

        if (i_accept) begin
            unique case (r_phase)
                PH_HEADER: begin
                    unique case (r_hdr_idx)
                        HDR_ID_LEN:    n_id_skip = b;
                        HDR_CMAP_TYPE: n_kind = (b != 8'd0) ? KIND_UNSUPPORTED : KIND_NONE;
                        HDR_IMG_TYPE: begin
                            if (r_kind == KIND_NONE) begin
                                if (b == IMG_TYPE_RAW) begin
                                    n_kind = KIND_RAW;
                                end else if (b == IMG_TYPE_RLE) begin
                                    n_kind = KIND_RLE;
                                end else begin
                                    n_kind = KIND_UNSUPPORTED;
                                end
                            end
                        end
                        HDR_WIDTH_LO:  n_width[7:0]   = b;
                        HDR_WIDTH_HI:  n_width[15:8]  = b;
                        HDR_HEIGHT_LO: n_height[7:0]  = b;
                        HDR_HEIGHT_HI: n_height[15:8] = b;
                        HDR_DEPTH: begin
                            n_four = (b == DEPTH_32);
                            if (b != DEPTH_24 && b != DEPTH_32 &&
                                r_kind != KIND_UNSUPPORTED) begin
                                n_kind = KIND_BAD_DEPTH;
                            end
                        end
                        default: ;
                    endcase
                    if (r_hdr_idx >= HDR_DESC) begin
                        n_top_down = b[DESC_TOP_DOWN_BIT];
                        n_left     = {16'd0, r_width} * {16'd0, r_height};
                        hdr_valid  = 1'b1;
                        if (r_kind == KIND_UNSUPPORTED) begin
                            hdr_status = ST_UNSUPPORTED;
                            n_phase    = PH_IDLE;
                        end else if (r_kind == KIND_BAD_DEPTH) begin
                            hdr_status = ST_BAD_DEPTH;
                            n_phase    = PH_IDLE;
                        end else if (r_id_skip != 8'd0) begin
                            n_phase = PH_SKIP;
                        end else begin
                            n_bip   = 2'd0;
                            n_phase = data_phase;
                        end
                    end else begin
                        n_hdr_idx = r_hdr_idx + 5'd1;
                    end
                end
                PH_SKIP: begin
                    n_id_skip = r_id_skip - 8'd1;
                    if (n_id_skip == 8'd0) begin
                        n_bip   = 2'd0;
                        n_phase = data_phase;
                    end
                end
                PH_PACKET: begin
                    n_repeat   = b[PKT_REPEAT_BIT];
                    n_pkt_left = {1'b0, b[6:0]} + 8'd1;
                    n_bip      = 2'd0;
                    n_phase    = PH_PIXEL;
                end
                PH_PIXEL: begin
                    n_colour = ((r_bip == 2'd0) ? 32'd0 : r_colour) | byte_shifted;
                    n_bip    = r_bip + 2'd1;
                    pix_done = (n_bip == 2'd0) || (!r_four && n_bip == 2'd3);
                    if (pix_done) begin
                        n_bip = 2'd0;
                        want  = (r_kind == KIND_RLE && r_repeat) ? r_pkt_left : 8'd1;
                        len   = (r_left < {24'd0, want}) ? r_left[7:0] : want;
                        if (len == 8'd0) begin
                            len = 8'd1;
                        end
                        run_valid      = 1'b1;
                        res.status     = ST_RUN;
                        res.dest_x     = r_col;
                        res.dest_y     = r_top_down ? r_row : (r_height - 16'd1 - r_row);
                        res.run_length = len;
                        res.red        = n_colour[23:16];
                        res.green      = n_colour[15:8];
                        res.blue       = n_colour[7:0];
                        res.alpha      = r_four ? n_colour[31:24] : ALPHA_OPAQUE;
                        res.image_done = (r_left == {24'd0, len});
                        n_left         = r_left - {24'd0, len};

                        // advance position: in row, one row, or many rows
                        pos     = {1'b0, r_col} + {9'd0, len};
                        pos_m_w = pos - {1'b0, r_width};
                        if (pos < {1'b0, r_width}) begin
                            n_col = pos[15:0];
                        end else if (pos_m_w < {1'b0, r_width}) begin
                            n_col = pos_m_w[15:0];
                            n_row = r_row + 16'd1;
                        end else if (!res.image_done && !i_beat.final_byte) begin
                            div_req.start    = 1'b1;
                            div_req.dividend = pos;
                            div_req.divisor  = r_width;
                        end

                        if (r_kind == KIND_RLE) begin
                            if (r_repeat || r_pkt_left <= 8'd1) begin
                                n_pkt_left = 8'd0;
                            end else begin
                                n_pkt_left = r_pkt_left - 8'd1;
                            end
                            if (n_pkt_left == 8'd0) begin
                                n_phase = PH_PACKET;
                            end
                        end
                        if (res.image_done) begin
                            n_phase = PH_IDLE;
                        end
                    end
                end
                PH_IDLE: ;
                default: ;
            endcase

            if (hdr_valid) begin
                res.status = hdr_status;
            end
            // final byte: truncation unless a run went out or the parser is idle (image complete, empty or rejected)
            if (i_beat.final_byte && n_phase != PH_IDLE && !run_valid) begin
                res        = '0;
                res.status = ST_TRUNCATED;
                hdr_valid  = 1'b1;
            end
            res.image_width  = n_width;
            res.image_height = n_height;

            if (i_beat.final_byte) begin
                n_hdr_idx  = '0;
                n_id_skip  = '0;
                n_kind     = KIND_NONE;
                n_width    = '0;
                n_height   = '0;
                n_four     = 1'b0;
                n_top_down = 1'b0;
                n_col      = '0;
                n_row      = '0;
                n_pkt_left = '0;
                n_repeat   = 1'b0;
                n_bip      = '0;
                n_colour   = '0;
                n_phase    = PH_HEADER;
                n_left     = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_idx  <= '0;
            r_id_skip  <= '0;
            r_kind     <= KIND_NONE;
            r_width    <= '0;
            r_height   <= '0;
            r_four     <= 1'b0;
            r_top_down <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_pkt_left <= '0;
            r_repeat   <= 1'b0;
            r_bip      <= '0;
            r_colour   <= '0;
            r_phase    <= PH_HEADER;
            r_left     <= '0;
        end else begin
            r_hdr_idx  <= n_hdr_idx;
            r_id_skip  <= n_id_skip;
            r_kind     <= n_kind;
            r_width    <= n_width;
            r_height   <= n_height;
            r_four     <= n_four;
            r_top_down <= n_top_down;
            r_col      <= n_col;
            r_row      <= n_row;
            r_pkt_left <= n_pkt_left;
            r_repeat   <= n_repeat;
            r_bip      <= n_bip;
            r_colour   <= n_colour;
            r_phase    <= n_phase;
            r_left     <= n_left;
        end
    end

    assign o_div_req   = div_req;
    assign o_res_valid = run_valid || hdr_valid;
    assign o_res       = res;

`ifndef ASSERT_OFF
    a_no_byte_while_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept |-> !i_div_rsp.busy)
        else $error("byte taken while row/column split pending");
    a_done_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.image_done) |=> (r_phase == PH_IDLE || r_phase == PH_HEADER))
        else $error("image complete but parser still in data");
    a_pixels_owed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PIXEL) |-> (r_left != 32'd0))
        else $error("pixel phase with no pixels left");
`endif

endmodule

### dv/tga_truecolor_rle_decoder_test.sv
// Self-checking testbench for tga_truecolor_rle_decoder: byte-stream TGA files in, runs out.
// A scoreboard class predicts header, run and error results per accepted byte.
// Depends on tgadec_pkg and the tga_truecolor_rle_decoder RTL.
module tga_truecolor_rle_decoder_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tgadec_pkg::*;

    // Watchdog: about two thousand bytes, each worst case a sender gap plus a receiver
    // stall plus the divider hold, two long hold-offs on top; this is many times that.
    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned RANDOM_BYTES = 1180;
    localparam byte unsigned DESC_TOP = 8'(1 << DESC_TOP_DOWN_BIT);

    // receiver stall patterns
    typedef enum {FLOW_FREE, FLOW_SPARSE, FLOW_PERIODIC, FLOW_HEAVY} t_out_flow;

    // ------------------------------------------------------------------
    // Scoreboard: mirrors the parser state, predicts the result of each
    // accepted byte and matches results in order.
    // ------------------------------------------------------------------
    class tga_decode_book;
        t_out_beat   decode_due[$];
        int unsigned errors;

        logic [4:0]  hdr_idx;
        logic [7:0]  id_left;
        logic [3:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic        four_bpp;
        logic        top_down;
        int unsigned col;
        int unsigned row;
        logic [7:0]  pkt_left;
        logic        pkt_rep;
        logic [1:0]  bip;
        logic [31:0] colour;
        logic [2:0]  phase;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            hdr_idx = '0; id_left = '0; kind = KIND_NONE;
            width = '0; height = '0; four_bpp = 1'b0; top_down = 1'b0;
            col = 0; row = 0; pkt_left = '0; pkt_rep = 1'b0;
            bip = '0; colour = '0; phase = PH_HEADER;
        endfunction

        // header done and ID field consumed: pick the data phase
        function void start_pixels();
            bip = '0;
            if (width == 0 || height == 0)
                phase = PH_IDLE;
            else if (kind == KIND_RLE)
                phase = PH_PACKET;
            else
                phase = PH_PIXEL;
        endfunction

        function t_out_beat blank(logic [2:0] st);
            t_out_beat r;
            r = '0;
            r.status = st;
            r.image_width = width;
            r.image_height = height;
            return r;
        endfunction

        // predict the result (if any) of one accepted byte
        function void take_byte(t_in_beat beat);
            logic [7:0]      b;
            logic            have;
            t_out_beat       res;
            int unsigned     need;
            longint unsigned total, done_px, px_left, len, pos;
            b = beat.data_byte;
            have = 1'b0;
            res = '0;
            case (phase)
                PH_HEADER: begin
                    case (hdr_idx)
                        HDR_ID_LEN:    id_left = b;
                        HDR_CMAP_TYPE: kind = (b != 0) ? KIND_UNSUPPORTED : KIND_NONE;
                        HDR_IMG_TYPE: begin
                            if (kind == KIND_NONE)
                                kind = (b == IMG_TYPE_RAW) ? KIND_RAW :
                                       (b == IMG_TYPE_RLE) ? KIND_RLE : KIND_UNSUPPORTED;
                        end
                        HDR_WIDTH_LO:  width[7:0] = b;
                        HDR_WIDTH_HI:  width[15:8] = b;
                        HDR_HEIGHT_LO: height[7:0] = b;
                        HDR_HEIGHT_HI: height[15:8] = b;
                        HDR_DEPTH: begin
                            four_bpp = (b == DEPTH_32);
                            // unsupported type wins over a bad depth
                            if (b != DEPTH_24 && b != DEPTH_32 && kind != KIND_UNSUPPORTED)
                                kind = KIND_BAD_DEPTH;
                        end
                        default: ;
                    endcase
                    if (hdr_idx >= HDR_DESC) begin
                        top_down = b[DESC_TOP_DOWN_BIT];
                        have = 1'b1;
                        if (kind == KIND_UNSUPPORTED) begin
                            res = blank(ST_UNSUPPORTED);
                            phase = PH_IDLE;
                        end else if (kind == KIND_BAD_DEPTH) begin
                            res = blank(ST_BAD_DEPTH);
                            phase = PH_IDLE;
                        end else begin
                            res = blank(ST_HEADER);
                            if (id_left != 0)
                                phase = PH_SKIP;
                            else
                                start_pixels();
                        end
                    end else begin
                        hdr_idx = hdr_idx + 5'd1;
                    end
                end
                PH_SKIP: begin
                    id_left = id_left - 8'd1;
                    if (id_left == 0)
                        start_pixels();
                end
                PH_PACKET: begin
                    pkt_rep = b[PKT_REPEAT_BIT];
                    pkt_left = {1'b0, b[6:0]} + 8'd1;
                    bip = '0;
                    phase = PH_PIXEL;
                end
                PH_PIXEL: begin
                    need = four_bpp ? 4 : 3;
                    if (bip == 0)
                        colour = '0;
                    colour = colour | (32'(b) << (8 * bip));
                    bip = bip + 2'd1;
                    if (bip >= need || bip == 0) begin
                        total = 64'(width) * 64'(height);
                        done_px = 64'(row) * 64'(width) + 64'(col);
                        px_left = (total > done_px) ? total - done_px : 0;
                        len = (kind == KIND_RLE && pkt_rep) ? 64'(pkt_left) : 1;
                        // repeat past the end is clipped to what is left
                        if (len > px_left)
                            len = px_left;
                        if (len == 0)
                            len = 1;
                        bip = '0;
                        res = blank(ST_RUN);
                        have = 1'b1;
                        res.dest_x = col[15:0];
                        res.dest_y = top_down ? row[15:0] : height - 16'd1 - row[15:0];
                        res.run_length = len[7:0];
                        res.red = colour[23:16];
                        res.green = colour[15:8];
                        res.blue = colour[7:0];
                        res.alpha = four_bpp ? colour[31:24] : ALPHA_OPAQUE;
                        pos = 64'(col) + len;
                        row = row + 32'(pos / width);
                        col = 32'(pos % width);
                        if (kind == KIND_RLE) begin
                            if (pkt_rep || pkt_left <= 1)
                                pkt_left = '0;
                            else
                                pkt_left = pkt_left - 8'd1;
                            if (pkt_left == 0)
                                phase = PH_PACKET;
                        end
                        if (row >= height) begin
                            res.image_done = 1'b1;
                            phase = PH_IDLE;
                        end
                    end
                end
                default: ;
            endcase
            // last byte of the file: flag an unfinished file, then back to reset
            if (beat.final_byte) begin
                if (phase != PH_IDLE && (!have || res.status == ST_HEADER)) begin
                    res = blank(ST_TRUNCATED);
                    have = 1'b1;
                end
                clear();
            end
            if (have)
                decode_due.push_back(res);
        endfunction

        function void check_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_decode(t_out_beat got);
            t_out_beat want;
            if (decode_due.size() == 0) begin
                $error("result with nothing pending: status %0d", got.status);
                errors++;
                return;
            end
            want = decode_due.pop_front();
            check_field("status", want.status, got.status);
            check_field("dest_x", want.dest_x, got.dest_x);
            check_field("dest_y", want.dest_y, got.dest_y);
            check_field("run_length", want.run_length, got.run_length);
            check_field("red", want.red, got.red);
            check_field("green", want.green, got.green);
            check_field("blue", want.blue, got.blue);
            check_field("alpha", want.alpha, got.alpha);
            check_field("image_width", want.image_width, got.image_width);
            check_field("image_height", want.image_height, got.image_height);
            check_field("image_done", want.image_done, got.image_done);
        endfunction
    endclass

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic      i_clk;
    logic      i_rst_n;
    logic      i_in_valid;
    logic      o_in_stall;
    t_in_beat  i_in_data;
    logic      o_out_valid;
    logic      i_out_stall;
    t_out_beat o_out_data;

    tga_truecolor_rle_decoder u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    tga_decode_book book = new();
    t_in_beat       byte_plan[$];   // every file back to back, final flag on each last byte
    int unsigned    bytes_taken = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // File builders
    // ------------------------------------------------------------------

    // mostly random, with the extremes showing up often
    function automatic byte unsigned pick_byte();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // packet header: repeat flag plus count of pixels (1..128)
    function automatic byte unsigned pkt(bit rep, int unsigned n);
        return (8'(rep) << PKT_REPEAT_BIT) | 8'(n - 1);
    endfunction

    // 18-byte header followed by the image ID field
    function automatic void put_header(ref byte unsigned f[$], input byte unsigned idl,
                                       input byte unsigned cmap, input byte unsigned itype,
                                       input int unsigned w, input int unsigned h,
                                       input byte unsigned depth, input byte unsigned desc);
        f.push_back(idl);
        f.push_back(cmap);
        f.push_back(itype);
        repeat (9) f.push_back(pick_byte());   // color map spec and origin: unused
        f.push_back(w[7:0]);
        f.push_back(w[15:8]);
        f.push_back(h[7:0]);
        f.push_back(h[15:8]);
        f.push_back(depth);
        f.push_back(desc);
        repeat (idl) f.push_back(pick_byte());
    endfunction

    function automatic void put_pixels(ref byte unsigned f[$], input bit four,
                                       input int unsigned n);
        repeat (n * (four ? 4 : 3)) f.push_back(pick_byte());
    endfunction

    // run-length body covering npix pixels, the last packet's count may exceed what is left; counts mostly short
    function automatic void put_packets(ref byte unsigned f[$], input bit four,
                                        input int unsigned npix);
        int unsigned cnt, k;
        bit          rep;
        while (npix > 0) begin
            rep = 1'($urandom_range(0, 1));
            cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 4);
            f.push_back(pkt(rep, cnt));
            k = (cnt < npix) ? cnt : npix;
            put_pixels(f, four, rep ? 1 : k);
            npix -= k;
        end
    endfunction

    function automatic void cut_file(ref byte unsigned f[$], input int unsigned n);
        while (f.size() > n)
            void'(f.pop_back());
    endfunction

    function automatic void queue_file(ref byte unsigned f[$]);
        t_in_beat beat;
        foreach (f[i]) begin
            beat.data_byte = f[i];
            beat.final_byte = (i == f.size() - 1);
            byte_plan.push_back(beat);
        end
        f.delete();
    endfunction

    // One random file; returns the bytes that count toward the random total.
    function automatic int unsigned random_file();
        byte unsigned f[$];
        int unsigned  w, h, npix, roll, bad, kept;
        bit           rle, four;
        byte unsigned idl, cmap, itype, depth;
        roll = $urandom_range(0, 99);
        if (roll < 4) begin
            // pure noise
            repeat ($urandom_range(1, 30)) f.push_back(pick_byte());
            kept = f.size();
            queue_file(f);
            return kept;
        end
        rle = 1'($urandom_range(0, 1));
        four = 1'($urandom_range(0, 1));
        itype = rle ? IMG_TYPE_RLE : IMG_TYPE_RAW;
        depth = four ? DEPTH_32 : DEPTH_24;
        cmap = 8'h00;
        idl = ($urandom_range(0, 39) == 0) ? 8'd255 :
              ($urandom_range(0, 2) == 0) ? 8'($urandom_range(1, 4)) : 8'd0;
        w = $urandom_range(1, 6);
        h = $urandom_range(1, 5);
        roll = $urandom_range(0, 99);
        if (roll < 4)
            w = 0;
        else if (roll < 8)
            h = 0;
        else if (roll < 12) begin
            // huge image: only a slice of it is ever sent
            w = $urandom_range(7, 65535);
            h = $urandom_range(1, 65535);
        end
        bad = $urandom_range(0, 99);
        if (bad < 4)
            cmap = 8'($urandom_range(1, 255));
        else if (bad < 8)
            itype = pick_byte();
        else if (bad < 12)
            depth = pick_byte();
        put_header(f, idl, cmap, itype, w, h, depth, pick_byte());
        npix = (w * h > 40) ? 40 : w * h;
        if (bad >= 12) begin
            if (rle)
                put_packets(f, four, npix);
            else
                put_pixels(f, four, npix);
        end
        if ($urandom_range(0, 9) == 0)
            cut_file(f, $urandom_range(1, f.size()));
        kept = f.size();
        // trailing bytes past a finished image are ignored by the block
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 3)) f.push_back(pick_byte());
        queue_file(f);
        return kept;
    endfunction

    // Directed files: every header outcome, truncation at each stage, clipping,
    // runs crossing rows, the divider path and the dimension extremes.
    function automatic void directed_files();
        byte unsigned f[$];
        // raw 24 bpp, bottom-up, black and white pixels; final on the last pixel byte
        put_header(f, 0, 0, IMG_TYPE_RAW, 2, 2, DEPTH_24, 8'h00);
        repeat (3) f.push_back(8'h00);
        repeat (3) f.push_back(8'hFF);
        put_pixels(f, 0, 2);
        queue_file(f);
        // RLE 32 bpp, top-down, ID field; repeat, literal, and a clipped repeat
        put_header(f, 2, 0, IMG_TYPE_RLE, 3, 2, DEPTH_32, DESC_TOP | 8'h08);
        f.push_back(pkt(1, 2));
        put_pixels(f, 1, 1);
        f.push_back(pkt(0, 2));
        put_pixels(f, 1, 2);
        f.push_back(pkt(1, 1));
        put_pixels(f, 1, 1);
        f.push_back(pkt(1, 128));
        put_pixels(f, 1, 1);
        repeat (2) f.push_back(pick_byte());
        queue_file(f);
        // color map present and bad depth: unsupported wins; trailing bytes ignored
        put_header(f, 0, 1, IMG_TYPE_RAW, 2, 2, 8'd16, 8'h00);
        repeat (3) f.push_back(pick_byte());
        queue_file(f);
        // unknown image type
        put_header(f, 0, 0, 8'd3, 2, 2, DEPTH_24, 8'h00);
        queue_file(f);
        // bad depth
        put_header(f, 0, 0, IMG_TYPE_RAW, 2, 2, 8'd16, DESC_TOP);
        queue_file(f);
        // empty image with an ID field, then bytes that are ignored
        put_header(f, 1, 0, IMG_TYPE_RLE, 0, 5, DEPTH_24, 8'h00);
        repeat (2) f.push_back(pick_byte());
        queue_file(f);
        // empty image ending on its descriptor: header result stands
        put_header(f, 0, 0, IMG_TYPE_RAW, 4, 0, DEPTH_32, 8'h00);
        queue_file(f);
        // file ends inside the header
        put_header(f, 0, 0, IMG_TYPE_RAW, 2, 2, DEPTH_24, 8'h00);
        cut_file(f, 5);
        queue_file(f);
        // file ends inside the ID field
        put_header(f, 4, 0, IMG_TYPE_RAW, 2, 2, DEPTH_24, 8'h00);
        cut_file(f, 20);
        queue_file(f);
        // file ends on the descriptor of a non-empty image: truncation replaces header
        put_header(f, 0, 0, IMG_TYPE_RAW, 3, 3, DEPTH_24, 8'h00);
        queue_file(f);
        // widest and tallest image; a full-length repeat run on the final byte
        put_header(f, 8'hFF, 8'h00, IMG_TYPE_RLE, 16'hFFFF, 16'hFFFF, DEPTH_32, 8'hFF);
        f.push_back(pkt(1, 128));
        put_pixels(f, 1, 1);
        queue_file(f);
        // one column: long repeats span many rows; the first goes through the divider, the second completes the image
        put_header(f, 0, 0, IMG_TYPE_RLE, 1, 200, DEPTH_24, 8'h00);
        f.push_back(pkt(1, 128));
        put_pixels(f, 0, 1);
        f.push_back(pkt(1, 72));
        put_pixels(f, 0, 1);
        queue_file(f);
        // a single repeat covering three rows
        put_header(f, 0, 0, IMG_TYPE_RLE, 2, 3, DEPTH_32, 8'h00);
        f.push_back(pkt(1, 6));
        put_pixels(f, 1, 1);
        f.push_back(pick_byte());
        queue_file(f);
        // file ends after three of four pixels
        put_header(f, 0, 0, IMG_TYPE_RLE, 2, 2, DEPTH_24, DESC_TOP);
        put_packets(f, 0, 3);
        f.push_back(pkt(0, 1));
        queue_file(f);
    endfunction

    // ------------------------------------------------------------------
    // Sender: bursts of beats separated by short random gaps
    // ------------------------------------------------------------------
    task automatic send_bytes();
        int unsigned burst, gap;
        burst = $urandom_range(1, 40);
        foreach (byte_plan[i]) begin
            if (burst == 0) begin
                gap = $urandom_range(1, 6);
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
                // now and then a long burst with no idling at all
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 40);
            end
            @(negedge i_clk);
            i_in_valid <= 1'b1;
            i_in_data <= byte_plan[i];
            do @(posedge i_clk); while (o_in_stall);
            book.take_byte(byte_plan[i]);
            bytes_taken++;
            burst--;
        end
        @(negedge i_clk);
        i_in_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: its own stall pattern, plus two long hold-offs that let
    // the result register fill and push back on the input.
    // ------------------------------------------------------------------
    initial begin : out_side
        t_out_flow   flow;
        int unsigned flow_left, tick, hold, holds_done, next_hold_at;
        logic        stall_now;
        i_out_stall = 1'b0;
        flow = FLOW_FREE;
        flow_left = 0;
        tick = 0;
        hold = 0;
        holds_done = 0;
        next_hold_at = 400;
        forever begin
            @(negedge i_clk);
            tick++;
            if (hold > 0) begin
                hold--;
                stall_now = 1'b1;
            end else if (holds_done < 2 && bytes_taken >= next_hold_at) begin
                hold = 500;
                holds_done++;
                next_hold_at += 900;
                stall_now = 1'b1;
            end else begin
                if (flow_left == 0) begin
                    flow = t_out_flow'($urandom_range(0, 3));
                    flow_left = $urandom_range(20, 200);
                end
                flow_left--;
                case (flow)
                    FLOW_FREE:     stall_now = 1'b0;
                    FLOW_SPARSE:   stall_now = ($urandom_range(0, 3) == 0);
                    FLOW_PERIODIC: stall_now = (tick % 3 != 0);
                    default:       stall_now = ($urandom_range(0, 9) < 7);
                endcase
            end
            i_out_stall <= stall_now;
        end
    end

    // every accepted result is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            book.check_decode(o_out_data);
    end

    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : main_flow
        int unsigned random_count;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        directed_files();
        random_count = 0;
        while (random_count < RANDOM_BYTES)
            random_count += random_file();
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        send_bytes();
        // drain: all predictions matched, then room for the divider hold and
        // anything stray the block might still emit
        while (book.decode_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (book.errors == 0 && book.decode_due.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
